// ===== rtl/core/tehs_pkg.sv =====
// Shared constants and codes for the timed event heap scheduler.
package tehs_pkg;

    localparam int HeapCapacity = 16;
    localparam int TimeWidth    = 48;
    localparam int DelayWidth   = 24;
    localparam int IdWidth      = 8;
    localparam int PosWidth     = 4;
    localparam int CountWidth   = 5;
    localparam int StepWidth    = 8;

    localparam logic [StepWidth-1:0] StepReset = 8'd4;

    typedef logic [1:0] t_code;

    localparam t_code OP_ADD  = 2'd0;
    localparam t_code OP_DEL  = 2'd1;
    localparam t_code OP_TICK = 2'd2;

    localparam t_code KIND_ADD  = 2'd0;
    localparam t_code KIND_DEL  = 2'd1;
    localparam t_code KIND_FIRE = 2'd2;

    localparam t_code ST_OK      = 2'd0;
    localparam t_code ST_FULL    = 2'd1;
    localparam t_code ST_BAD_POS = 2'd2;

endpackage

// ===== rtl/core/timed_event_heap_scheduler_core.sv =====
// Timed event queue held as a binary min-heap in one synchronous memory.
//
// Input channel i_valid/o_ready carries one beat per operation: add (delay and
// event id), delete (heap position) or tick. Output channel o_valid/i_ready
// returns result beats; add and delete give exactly one beat, a tick gives one
// beat per fired event, or none, with o_last on the final one.
// The heap lives in a single memory of entries with a registered read;
// every heap step is a read followed by a compare and a write-back.
// An add climbs from the new leaf toward the root, moving each parent down
// while its time is later than the new entry's. A delete shifts the entries
// on the path from its position to the root down one level, fetches the
// last entry into the root and sifts it down, reading the left and then the
// right child. A tick tests the root and, for each fired event, runs the
// delete sequence from the root and a further test.
// One item is worked on at a time; o_ready is high only while idle.
// The result register lets the next item start while a beat waits, and a
// stalled receiver holds the sequencer only when a further beat is due.
// Reset empties the heap, clears the current time and sets the tick step
// to four; memory contents need no clearing.
module timed_event_heap_scheduler_core
    import tehs_pkg::*;
#(
    parameter int HEAP_CAPACITY = HeapCapacity,
    parameter int TIME_WIDTH    = TimeWidth
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_op,
    input  logic [DelayWidth-1:0] i_delay,
    input  logic [IdWidth-1:0]    i_event_id,
    input  logic [PosWidth-1:0]   i_position,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_kind,
    output logic [IdWidth-1:0]    o_fired_id,
    output logic [CountWidth-1:0] o_count,
    output logic [1:0]            o_status,
    output logic                  o_last,
    input  logic                  i_cfg_we,
    input  logic [StepWidth-1:0]  i_cfg_wdata
);

    localparam int AW = (HEAP_CAPACITY > 1) ? $clog2(HEAP_CAPACITY) : 1;
    localparam int CW = $clog2(HEAP_CAPACITY + 1);
    localparam int EW = TIME_WIDTH + IdWidth;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_UP    = 4'd1;
    localparam logic [3:0] S_UPC   = 4'd2;
    localparam logic [3:0] S_DUP   = 4'd3;
    localparam logic [3:0] S_DUPC  = 4'd4;
    localparam logic [3:0] S_LAST  = 4'd5;
    localparam logic [3:0] S_DN    = 4'd6;
    localparam logic [3:0] S_DNL   = 4'd7;
    localparam logic [3:0] S_DNR   = 4'd8;
    localparam logic [3:0] S_TCHK  = 4'd9;
    localparam logic [3:0] S_TCMP  = 4'd10;
    localparam logic [3:0] S_TPUSH = 4'd11;
    localparam logic [3:0] S_EMIT  = 4'd12;

    logic [EW-1:0] r_mem [HEAP_CAPACITY];
    logic [EW-1:0] r_rd;
    logic          rd_en, we;
    logic [AW-1:0] rd_addr, wa;
    logic [EW-1:0] wd;

    logic [3:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [TIME_WIDTH-1:0] r_time, n_time;
    logic [StepWidth-1:0]  r_step;
    logic [AW-1:0]         r_i, n_i, r_m, n_m;
    logic [EW-1:0]         r_ent, n_ent, r_best, n_best;
    logic                  r_msel, n_msel;
    t_code                 r_op, n_op, r_kind, n_kind, r_status, n_status;
    logic                  r_hit, n_hit, r_pend, n_pend;
    logic [IdWidth-1:0]    r_hid, n_hid, r_pid, n_pid;

    logic                  r_ov, n_ov;
    t_code                 r_okind, n_okind, r_ostat, n_ostat;
    logic [IdWidth-1:0]    r_oid, n_oid;
    logic [CW-1:0]         r_ocnt, n_ocnt;
    logic                  r_olast, n_olast;

    logic                  slot_free;
    logic [AW-1:0]         parent, last_addr;
    logic [AW+1:0]         l_ext, rr_ext;
    logic                  l_in, r_in;

    assign slot_free = !r_ov || i_ready;
    assign parent    = (r_i - AW'(1)) >> 1;
    assign last_addr = AW'(r_count - CW'(1));
    assign l_ext     = {1'b0, r_i, 1'b1};
    assign rr_ext    = l_ext + (AW+2)'(1);
    assign l_in      = 32'(l_ext) < 32'(r_count);
    assign r_in      = 32'(rr_ext) < 32'(r_count);

    always_comb begin
        logic          lsmall;
        logic [EW-1:0] best;
        logic          msel;
        logic [AW-1:0] m;
        logic          decide;
        logic          done;

        lsmall = 1'b0;
        best = r_best;
        msel = r_msel;
        m = r_m;
        decide = 1'b0;
        done = 1'b0;

        n_state = r_state; n_count = r_count; n_time = r_time;
        n_i = r_i; n_m = r_m; n_ent = r_ent; n_best = r_best; n_msel = r_msel;
        n_op = r_op; n_kind = r_kind; n_status = r_status;
        n_hit = r_hit; n_hid = r_hid; n_pend = r_pend; n_pid = r_pid;
        n_ov = r_ov && !i_ready;
        n_okind = r_okind; n_oid = r_oid; n_ocnt = r_ocnt;
        n_ostat = r_ostat; n_olast = r_olast;
        rd_en = 1'b0; rd_addr = '0; we = 1'b0; wa = '0; wd = r_ent;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op = i_op;
                    case (i_op)
                        OP_ADD: begin
                            n_kind = KIND_ADD;
                            if (32'(r_count) >= HEAP_CAPACITY) begin
                                n_status = ST_FULL;
                                n_state = S_EMIT;
                            end else begin
                                n_status = ST_OK;
                                n_ent = {r_time + TIME_WIDTH'(i_delay), i_event_id};
                                n_i = AW'(r_count);
                                n_count = r_count + CW'(1);
                                n_state = S_UP;
                            end
                        end
                        OP_DEL: begin
                            n_kind = KIND_DEL;
                            if (32'(i_position) >= 32'(r_count)) begin
                                n_status = ST_BAD_POS;
                                n_state = S_EMIT;
                            end else begin
                                n_status = ST_OK;
                                n_i = AW'(i_position);
                                n_state = S_DUP;
                            end
                        end
                        OP_TICK: begin
                            n_time = r_time + TIME_WIDTH'(r_step);
                            n_pend = 1'b0;
                            n_state = S_TCHK;
                        end
                        default: ;
                    endcase
                end
            end
            S_UP: begin
                if (r_i == '0) begin
                    we = 1'b1; wa = r_i; wd = r_ent;
                    n_state = S_EMIT;
                end else begin
                    rd_en = 1'b1; rd_addr = parent;
                    n_state = S_UPC;
                end
            end
            S_UPC: begin
                if (r_rd[EW-1:IdWidth] > r_ent[EW-1:IdWidth]) begin
                    we = 1'b1; wa = r_i; wd = r_rd;
                    n_i = parent;
                    n_state = S_UP;
                end else begin
                    we = 1'b1; wa = r_i; wd = r_ent;
                    n_state = S_EMIT;
                end
            end
            S_DUP: begin
                rd_en = 1'b1;
                if (r_i == '0) begin
                    rd_addr = last_addr;
                    n_state = S_LAST;
                end else begin
                    rd_addr = parent;
                    n_state = S_DUPC;
                end
            end
            S_DUPC: begin
                we = 1'b1; wa = r_i; wd = r_rd;
                n_i = parent;
                n_state = S_DUP;
            end
            S_LAST: begin
                n_ent = r_rd;
                n_count = r_count - CW'(1);
                n_i = '0;
                n_state = S_DN;
            end
            S_DN: begin
                if (!l_in) begin
                    we = 1'b1; wa = r_i; wd = r_ent;
                    done = 1'b1;
                end else begin
                    rd_en = 1'b1; rd_addr = l_ext[AW-1:0];
                    n_state = S_DNL;
                end
            end
            S_DNL: begin
                lsmall = r_rd[EW-1:IdWidth] < r_ent[EW-1:IdWidth];
                best = lsmall ? r_rd : r_ent;
                msel = lsmall;
                m = l_ext[AW-1:0];
                if (r_in) begin
                    rd_en = 1'b1; rd_addr = rr_ext[AW-1:0];
                    n_best = best; n_msel = msel; n_m = m;
                    n_state = S_DNR;
                end else begin
                    decide = 1'b1;
                end
            end
            S_DNR: begin
                if (r_rd[EW-1:IdWidth] < r_best[EW-1:IdWidth]) begin
                    best = r_rd; msel = 1'b1; m = rr_ext[AW-1:0];
                end
                decide = 1'b1;
            end
            S_TCHK: begin
                if (r_count == '0) begin
                    n_hit = 1'b0;
                    n_state = S_TPUSH;
                end else begin
                    rd_en = 1'b1; rd_addr = '0;
                    n_state = S_TCMP;
                end
            end
            S_TCMP: begin
                n_hit = r_rd[EW-1:IdWidth] <= r_time;
                n_hid = r_rd[IdWidth-1:0];
                n_state = S_TPUSH;
            end
            S_TPUSH: begin
                if (!r_pend || slot_free) begin
                    if (r_pend) begin
                        n_ov = 1'b1; n_okind = KIND_FIRE; n_oid = r_pid;
                        n_ocnt = r_count; n_ostat = ST_OK; n_olast = !r_hit;
                    end
                    n_pend = r_hit;
                    n_pid = r_hid;
                    if (r_hit) begin
                        n_i = '0;
                        n_state = S_DUP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_ov = 1'b1; n_okind = r_kind; n_oid = '0;
                    n_ocnt = r_count; n_ostat = r_status; n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (decide) begin
            if (!msel) begin
                we = 1'b1; wa = r_i; wd = r_ent;
                done = 1'b1;
            end else begin
                we = 1'b1; wa = r_i; wd = best;
                n_i = m;
                n_state = S_DN;
            end
        end
        if (done) begin
            n_state = (r_op == OP_DEL) ? S_EMIT : S_TCHK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_time  <= '0;
            r_step  <= StepReset;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_time  <= n_time;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_m <= n_m; r_ent <= n_ent; r_best <= n_best; r_msel <= n_msel;
        r_op <= n_op; r_kind <= n_kind; r_status <= n_status;
        r_hit <= n_hit; r_hid <= n_hid; r_pid <= n_pid;
        r_okind <= n_okind; r_oid <= n_oid; r_ocnt <= n_ocnt;
        r_ostat <= n_ostat; r_olast <= n_olast;
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_ov;
    assign o_kind     = r_okind;
    assign o_fired_id = r_oid;
    assign o_count    = CountWidth'(r_ocnt);
    assign o_status   = r_ostat;
    assign o_last     = r_olast;

endmodule

// ===== rtl/core/tehs_checker.sv =====
// Port-level checker for the timed event heap scheduler, with its bind.
module tehs_checker
    import tehs_pkg::*;
#(
    parameter int HEAP_CAPACITY = HeapCapacity
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [1:0]            o_kind,
    input logic [IdWidth-1:0]    o_fired_id,
    input logic [CountWidth-1:0] o_count,
    input logic [1:0]            o_status,
    input logic                  o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_fired_id))
        else $error("Stalled result beat changed.");

    a_fire_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_FIRE |-> o_status == ST_OK)
        else $error("Fired event carries an error status.");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_FIRE |-> o_last && o_fired_id == '0)
        else $error("Add or delete result is not a single beat.");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 32'(o_count) <= HEAP_CAPACITY)
        else $error("Entry count exceeds the heap capacity.");

endmodule

bind timed_event_heap_scheduler_core tehs_checker #(
    .HEAP_CAPACITY(HEAP_CAPACITY)
) u_tehs_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_kind(o_kind),
    .o_fired_id(o_fired_id),
    .o_count(o_count),
    .o_status(o_status),
    .o_last(o_last)
);

// ===== dv/tb.sv =====
// Self-checking testbench for the timed event heap scheduler core.
`timescale 1ns / 100ps

class heap_scoreboard;
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] fired_id;
        logic [4:0] count;
        logic [1:0] status;
        logic       last;
    } beat_t;

    logic [47:0] due_q[16];
    logic [7:0]  id_q[16];
    int          held;
    logic [47:0] now_time;
    logic [7:0]  step;
    beat_t       pending[$];
    int          errors;

    function new();
        held = 0;
        now_time = '0;
        step = tehs_pkg::StepReset;
        errors = 0;
    endfunction

    function void swap_slots(int a, int b);
        logic [47:0] t;
        logic [7:0]  e;
        t = due_q[a]; e = id_q[a];
        due_q[a] = due_q[b]; id_q[a] = id_q[b];
        due_q[b] = t; id_q[b] = e;
    endfunction

    function void remove_slot(int p);
        int i, l, r, m;
        while (p > 0) begin
            swap_slots((p - 1) / 2, p);
            p = (p - 1) / 2;
        end
        due_q[0] = due_q[held - 1];
        id_q[0] = id_q[held - 1];
        held--;
        i = 0;
        forever begin
            l = 2 * i + 1; r = l + 1; m = i;
            if (l < held && due_q[l] < due_q[i]) m = l;
            if (r < held && due_q[r] < due_q[m]) m = r;
            if (m == i) break;
            swap_slots(i, m);
            i = m;
        end
    endfunction

    function void push_beat(logic [1:0] k, logic [7:0] id, logic [1:0] st, logic lst);
        beat_t b;
        b.kind = k; b.fired_id = id; b.count = held[4:0]; b.status = st; b.last = lst;
        pending.push_back(b);
    endfunction

    function void note_item(logic [1:0] op, logic [23:0] dly, logic [7:0] id,
                            logic [3:0] pos);
        int i, n;
        logic [7:0] fid;
        if (op == tehs_pkg::OP_ADD) begin
            if (held >= 16) begin
                push_beat(tehs_pkg::KIND_ADD, 8'd0, tehs_pkg::ST_FULL, 1'b1);
            end else begin
                i = held;
                due_q[i] = now_time + 48'(dly);
                id_q[i] = id;
                held++;
                while (i > 0 && due_q[(i - 1) / 2] > due_q[i]) begin
                    swap_slots((i - 1) / 2, i);
                    i = (i - 1) / 2;
                end
                push_beat(tehs_pkg::KIND_ADD, 8'd0, tehs_pkg::ST_OK, 1'b1);
            end
        end else if (op == tehs_pkg::OP_DEL) begin
            if (int'(pos) >= held) begin
                push_beat(tehs_pkg::KIND_DEL, 8'd0, tehs_pkg::ST_BAD_POS, 1'b1);
            end else begin
                remove_slot(int'(pos));
                push_beat(tehs_pkg::KIND_DEL, 8'd0, tehs_pkg::ST_OK, 1'b1);
            end
        end else if (op == tehs_pkg::OP_TICK) begin
            n = 0;
            now_time = now_time + 48'(step);
            while (held > 0 && due_q[0] <= now_time) begin
                fid = id_q[0];
                remove_slot(0);
                push_beat(tehs_pkg::KIND_FIRE, fid, tehs_pkg::ST_OK, 1'b0);
                n++;
            end
            if (n > 0) pending[$].last = 1'b1;
        end
    endfunction

    function void check_beat(beat_t got);
        beat_t want;
        if (pending.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.kind != want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind); errors++;
        end
        if (got.fired_id != want.fired_id) begin
            $error("fired_id: expected %0d, got %0d", want.fired_id, got.fired_id); errors++;
        end
        if (got.count != want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count); errors++;
        end
        if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status); errors++;
        end
        if (got.last != want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last); errors++;
        end
    endfunction
endclass

module tb;
    import tehs_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [1:0]            i_op = '0;
    logic [DelayWidth-1:0] i_delay = '0;
    logic [IdWidth-1:0]    i_event_id = '0;
    logic [PosWidth-1:0]   i_position = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [1:0]            o_kind;
    logic [IdWidth-1:0]    o_fired_id;
    logic [CountWidth-1:0] o_count;
    logic [1:0]            o_status;
    logic                  o_last;
    logic                  i_cfg_we = 1'b0;
    logic [StepWidth-1:0]  i_cfg_wdata = '0;

    heap_scoreboard sb = new();
    bit  src_idle_on = 1'b1;
    bit  sink_idle_on = 1'b1;
    bit  hold_sink = 1'b0;
    int  quiet_cycles = 0;

    always #2 i_clk = ~i_clk;

    timed_event_heap_scheduler_core dut (.*);

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_beat({o_kind, o_fired_id, o_count, o_status, o_last});
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : sink_drive
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                i_ready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 17);
                i_ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(logic [1:0] op, logic [23:0] dly, logic [7:0] id,
                             logic [3:0] pos);
        int n;
        if (src_idle_on && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 17);
            i_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op; i_delay <= dly; i_event_id <= id; i_position <= pos;
        do @(posedge i_clk); while (!o_ready);
        if (i_rst_n) sb.note_item(op, dly, id, pos);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic set_step(logic [7:0] v);
        drain();
        i_cfg_we <= 1'b1; i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.step = v;
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            send_item(OP_ADD, ($urandom_range(0, 3) == 0) ? 24'($urandom) :
                      24'($urandom_range(0, 40)), 8'($urandom), 4'($urandom));
        else if (r < 65)
            send_item(OP_DEL, 24'($urandom), 8'($urandom),
                      4'($urandom_range(0, sb.held < 16 ? sb.held : 15)));
        else if (r < 98)
            send_item(OP_TICK, 24'($urandom), 8'($urandom), 4'($urandom));
        else
            send_item(2'd3, 24'($urandom), 8'($urandom), 4'($urandom));
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_item(OP_DEL, 24'd0, 8'd0, 4'd0);
        send_item(OP_TICK, 24'd0, 8'd0, 4'd0);
        send_item(OP_ADD, 24'hFFFFFF, 8'hFF, 4'd15);
        send_item(OP_ADD, 24'd0, 8'd0, 4'd0);
        send_item(OP_ADD, 24'd4, 8'hA5, 4'd0);
        send_item(OP_ADD, 24'd4, 8'h5A, 4'd0);
        send_item(2'd3, 24'hFFFFFF, 8'hFF, 4'hF);
        send_item(OP_DEL, 24'd0, 8'd0, 4'd3);
        send_item(OP_DEL, 24'd0, 8'd0, 4'd15);
        send_item(OP_TICK, 24'd0, 8'd0, 4'd0);
        for (int k = 0; k < 15; k++) send_item(OP_ADD, 24'(k % 3), 8'(k), 4'd0);
        send_item(OP_ADD, 24'd1, 8'd1, 4'd0);
        set_step(8'd0);
        send_item(OP_TICK, 24'd0, 8'd0, 4'd0);
        set_step(8'd255);
        send_item(OP_TICK, 24'd0, 8'd0, 4'd0);
        send_item(OP_TICK, 24'd0, 8'd0, 4'd0);
        set_step(8'd1);
        for (int k = 0; k < 20; k++) send_item(OP_ADD, 24'($urandom_range(0, 6)),
                                               8'($urandom), 4'd0);
        fork
            begin
                hold_sink = 1'b1;
                repeat (300) @(negedge i_clk);
                hold_sink = 1'b0;
            end
            begin
                for (int k = 0; k < 6; k++) send_item(OP_TICK, 24'd0, 8'd0, 4'd0);
                i_valid <= 1'b0;
            end
        join
        set_step(8'($urandom_range(1, 255)));
        for (int k = 0; k < 60; k++) random_item();
        set_step(8'd4);
        for (int k = 0; k < 60; k++) random_item();
        set_step(8'd255);
        for (int k = 0; k < 35; k++) random_item();
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        for (int k = 0; k < 40; k++) random_item();
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ===== timed_event_heap_scheduler_core.f =====
rtl/core/tehs_pkg.sv
rtl/core/timed_event_heap_scheduler_core.sv
rtl/core/tehs_checker.sv
dv/tb.sv
